[src/qr_segment_data_packer_core_assert.svh]
// Assertion macros used by the packer checker.
`ifndef QR_SEGMENT_DATA_PACKER_CORE_ASSERT_SVH
`define QR_SEGMENT_DATA_PACKER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QSDP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define QSDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/qsdp_pkg.sv]
package qsdp_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned EciW    = 20;
  localparam int unsigned ValueW  = 24;
  localparam int unsigned LengthW = 5;
  localparam int unsigned StatusW = 2;
  localparam int unsigned AccW    = 11;
  localparam int unsigned CountW  = 2;

  localparam logic [EciW-1:0] EciLimit = 20'd1000000;
  localparam logic [EciW-1:0] EciOneByte = 20'd128;
  localparam logic [EciW-1:0] EciTwoByte = 20'd16384;

  localparam logic [LengthW-1:0] LenNumGroup   = 5'd10;
  localparam logic [LengthW-1:0] LenAlnumPair  = 5'd11;
  localparam logic [LengthW-1:0] LenAlnumSingle = 5'd6;
  localparam logic [LengthW-1:0] LenByte       = 5'd8;
  localparam logic [LengthW-1:0] LenEciShort   = 5'd8;
  localparam logic [LengthW-1:0] LenEciMid     = 5'd16;
  localparam logic [LengthW-1:0] LenEciLong    = 5'd24;

  typedef enum logic [1:0] {
    MODE_NUMERIC = 2'd0,
    MODE_ALNUM   = 2'd1,
    MODE_BYTE    = 2'd2,
    MODE_ECI     = 2'd3
  } qsdp_mode_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_CHAR  = 2'd1,
    STATUS_ECI_RANGE = 2'd2
  } qsdp_status_e;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic [EciW-1:0]  eci_value;
    logic             last;
  } qsdp_item_t;

  typedef struct packed {
    logic [ValueW-1:0]  chunk_value;
    logic [LengthW-1:0] chunk_length;
    qsdp_status_e       status;
    logic               segment_end;
  } qsdp_result_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] idx;
  } qsdp_alnum_t;

  // Maps a character code onto the 45-symbol alphanumeric table.
  function automatic qsdp_alnum_t alnum_lookup(logic [CharW-1:0] code);
    qsdp_alnum_t r;
    r.ok  = 1'b1;
    r.idx = 6'd0;
    if (code >= 8'h30 && code <= 8'h39) begin
      r.idx = 6'(code - 8'h30);
    end else if (code >= 8'h41 && code <= 8'h5A) begin
      r.idx = 6'(code - 8'h41 + 8'd10);
    end else begin
      unique case (code)
        8'h20:   r.idx = 6'd36;
        8'h24:   r.idx = 6'd37;
        8'h25:   r.idx = 6'd38;
        8'h2A:   r.idx = 6'd39;
        8'h2B:   r.idx = 6'd40;
        8'h2D:   r.idx = 6'd41;
        8'h2E:   r.idx = 6'd42;
        8'h2F:   r.idx = 6'd43;
        8'h3A:   r.idx = 6'd44;
        default: r.ok  = 1'b0;
      endcase
    end
    return r;
  endfunction

endpackage

[src/qsdp_in_if.sv]
interface qsdp_in_if;
  import qsdp_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic [EciW-1:0]  eci_value;
  logic             last;

  modport source (output valid, output char_code, output eci_value, output last,
                  input ready);
  modport sink   (input valid, input char_code, input eci_value, input last,
                  output ready);
endinterface

[src/qsdp_out_if.sv]
interface qsdp_out_if;
  import qsdp_pkg::*;

  logic               valid;
  logic               ready;
  logic [ValueW-1:0]  chunk_value;
  logic [LengthW-1:0] chunk_length;
  logic [StatusW-1:0] status;
  logic               segment_end;

  modport source (output valid, output chunk_value, output chunk_length,
                  output status, output segment_end, input ready);
  modport sink   (input valid, input chunk_value, input chunk_length,
                  input status, input segment_end, output ready);
endinterface

[src/qsdp_in_stage.sv]
module qsdp_in_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  qsdp_in_if.sink              in_i,
  input  logic                 advance_i,
  output logic                 valid_o,
  output qsdp_pkg::qsdp_item_t item_o
);
  import qsdp_pkg::*;

  logic       valid_q;
  qsdp_item_t item_q;

  // The register takes a new transfer when empty or when its item moves on.
  assign in_i.ready = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q <= '{char_code: in_i.char_code, eci_value: in_i.eci_value, last: in_i.last};
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

[src/qsdp_encoder.sv]
module qsdp_encoder (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_wdata_i,
  input  qsdp_pkg::qsdp_item_t   item_i,
  input  logic                   advance_i,
  output logic                   has_result_o,
  output qsdp_pkg::qsdp_result_t result_o
);
  import qsdp_pkg::*;

  qsdp_mode_e        mode_q;
  logic [AccW-1:0]   acc_q, acc_d;
  logic [CountW-1:0] count_q, count_d;

  logic              is_digit;
  logic [3:0]        digit;
  qsdp_alnum_t       alnum;
  logic [AccW-1:0]   num_acc;
  logic [AccW-1:0]   alnum_acc;
  logic [CountW-1:0] count_inc;

  // Character classification and the constant multiply-add for each mode.
  assign is_digit  = (item_i.char_code >= 8'h30) && (item_i.char_code <= 8'h39);
  assign digit     = 4'(item_i.char_code - 8'h30);
  assign alnum     = alnum_lookup(item_i.char_code);
  assign num_acc   = AccW'(acc_q * 11'd10 + {7'd0, digit});
  assign alnum_acc = AccW'(acc_q * 11'd45 + {5'd0, alnum.idx});
  assign count_inc = count_q + 2'd1;

  // Result and next group state for the item in the input register.
  always_comb begin
    has_result_o = 1'b1;
    result_o     = '{chunk_value: '0, chunk_length: '0, status: STATUS_OK,
                     segment_end: item_i.last};
    acc_d        = '0;
    count_d      = '0;
    unique case (mode_q)
      MODE_NUMERIC: begin
        if (!is_digit) begin
          result_o.status      = STATUS_BAD_CHAR;
          result_o.segment_end = 1'b1;
        end else if (count_inc >= 2'd3) begin
          result_o.chunk_value  = ValueW'(num_acc);
          result_o.chunk_length = LenNumGroup;
        end else if (item_i.last) begin
          result_o.chunk_value  = ValueW'(num_acc);
          result_o.chunk_length = LengthW'({count_inc, 1'b0} + count_inc + 3'd1);
        end else begin
          has_result_o = 1'b0;
          acc_d        = num_acc;
          count_d      = count_inc;
        end
      end
      MODE_ALNUM: begin
        if (!alnum.ok) begin
          result_o.status      = STATUS_BAD_CHAR;
          result_o.segment_end = 1'b1;
        end else if (count_inc >= 2'd2) begin
          result_o.chunk_value  = ValueW'(alnum_acc);
          result_o.chunk_length = LenAlnumPair;
        end else if (item_i.last) begin
          result_o.chunk_value  = ValueW'(alnum_acc);
          result_o.chunk_length = LenAlnumSingle;
        end else begin
          has_result_o = 1'b0;
          acc_d        = alnum_acc;
          count_d      = count_inc;
        end
      end
      MODE_BYTE: begin
        result_o.chunk_value  = ValueW'(item_i.char_code);
        result_o.chunk_length = LenByte;
      end
      MODE_ECI: begin
        result_o.segment_end = 1'b1;
        if (item_i.eci_value >= EciLimit) begin
          result_o.status = STATUS_ECI_RANGE;
        end else if (item_i.eci_value < EciOneByte) begin
          result_o.chunk_value  = ValueW'(item_i.eci_value);
          result_o.chunk_length = LenEciShort;
        end else if (item_i.eci_value < EciTwoByte) begin
          result_o.chunk_value  = {8'd0, 2'b10, item_i.eci_value[13:0]};
          result_o.chunk_length = LenEciMid;
        end else begin
          result_o.chunk_value  = {3'b110, 1'b0, item_i.eci_value};
          result_o.chunk_length = LenEciLong;
        end
      end
      default: begin
        has_result_o = 1'b0;
      end
    endcase
  end

  // Mode register and group state; a mode write restarts the group.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_BYTE;
      acc_q   <= '0;
      count_q <= '0;
    end else if (cfg_we_i) begin
      mode_q  <= qsdp_mode_e'(cfg_wdata_i);
      acc_q   <= '0;
      count_q <= '0;
    end else if (advance_i) begin
      acc_q   <= acc_d;
      count_q <= count_d;
    end
  end
endmodule

[src/qsdp_out_stage.sv]
module qsdp_out_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  qsdp_pkg::qsdp_result_t result_i,
  output logic                   can_load_o,
  qsdp_out_if.source             out_o
);
  import qsdp_pkg::*;

  logic         valid_q;
  qsdp_result_t result_q;

  // A new result may enter when the register is empty or drains this cycle.
  assign can_load_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_load_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && can_load_o) begin
      result_q <= result_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.chunk_value  = result_q.chunk_value;
  assign out_o.chunk_length = result_q.chunk_length;
  assign out_o.status       = StatusW'(result_q.status);
  assign out_o.segment_end  = result_q.segment_end;
endmodule

[src/qr_segment_data_packer_core.sv]
// Channel   Direction  Transfer moves
// in_i      sink       char_code[7:0], eci_value[19:0], last
// out_o     source     chunk_value[23:0], chunk_length[4:0], status[1:0], segment_end
// cfg       write      segment_mode[1:0] on cfg_we_i, no read-back
//
// One item is taken per cycle unless out_o stalls; item and result are registered.
// An item that only adds to a digit or character group gives no result.
// Reset selects byte mode and clears the group, the input and the result register.
// A stalled output holds its result; the input register takes one more item and
// then input ready drops until the result is taken.
module qr_segment_data_packer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  qsdp_in_if.sink    in_i,
  qsdp_out_if.source out_o
);
  import qsdp_pkg::*;

  logic         in_valid;
  qsdp_item_t   item;
  logic         advance;
  logic         has_result;
  qsdp_result_t result;
  logic         can_load;

  // The buffered item moves on whenever the result register can accept.
  assign advance = in_valid && can_load;

  qsdp_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .valid_o   (in_valid),
    .item_o    (item)
  );

  qsdp_encoder u_encoder (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_i       (item),
    .advance_i    (advance),
    .has_result_o (has_result),
    .result_o     (result)
  );

  qsdp_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance && has_result),
    .result_i   (result),
    .can_load_o (can_load),
    .out_o      (out_o)
  );
endmodule

[src/qsdp_checker.sv]
`include "qr_segment_data_packer_core_assert.svh"

module qsdp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [23:0] chunk_value_i,
  input logic [4:0]  chunk_length_i,
  input logic [1:0]  status_i,
  input logic        segment_end_i
);
  import qsdp_pkg::*;

  // A stalled result stays offered.
  `QSDP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // Error results carry no bits and close the segment.
  `QSDP_ASSERT_NOW(a_err_shape, clk_i, rst_ni,
    out_valid_i && (status_i != StatusW'(STATUS_OK)),
    (chunk_length_i == 5'd0) && segment_end_i && (chunk_value_i == 24'd0))

  // Good results use one of the chunk lengths of the four modes.
  `QSDP_ASSERT_NOW(a_ok_length, clk_i, rst_ni,
    out_valid_i && (status_i == StatusW'(STATUS_OK)),
    (chunk_length_i == 5'd4) || (chunk_length_i == 5'd6) || (chunk_length_i == 5'd7) ||
    (chunk_length_i == 5'd8) || (chunk_length_i == 5'd10) || (chunk_length_i == 5'd11) ||
    (chunk_length_i == 5'd16) || (chunk_length_i == 5'd24))

  // No bit is set above the stated chunk length.
  `QSDP_ASSERT_NOW(a_value_fits, clk_i, rst_ni, out_valid_i,
    (chunk_value_i >> chunk_length_i) == 24'd0)
endmodule

bind qr_segment_data_packer_core qsdp_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .chunk_value_i  (out_o.chunk_value),
  .chunk_length_i (out_o.chunk_length),
  .status_i       (out_o.status),
  .segment_end_i  (out_o.segment_end)
);
